@@ rtl/bdlp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // APB register map: register i at byte address 4*i
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned THRESH_W = 16;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_ENABLE   = 2'd2
  } reg_idx_t;

  localparam logic [THRESH_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [THRESH_W-1:0] LONG_RST     = 16'd1000;
  localparam logic                ENABLE_RST   = 1'b1;

  // Settings and write strobe from the register block to the engine
  typedef struct packed {
    logic [THRESH_W-1:0] debounce_ticks;
    logic [THRESH_W-1:0] long_press_ticks;
    logic                enable;
    logic                flag_clr;
  } cfg_ctl_t;

  typedef struct packed {
    logic level;
    logic take_press;
    logic take_long;
  } in_item_t;

  typedef struct packed {
    logic pressed;
    logic long_pressed;
    logic debounced_level;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bdlp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bdlp_in_if;
  logic valid;
  logic ready;
  logic level;
  logic take_press;
  logic take_long;

  modport source (output valid, output level, output take_press, output take_long,
                  input ready);
  modport sink   (input valid, input level, input take_press, input take_long,
                  output ready);
endinterface

interface bdlp_out_if;
  logic valid;
  logic ready;
  logic pressed;
  logic long_pressed;
  logic debounced_level;

  modport source (output valid, output pressed, output long_pressed,
                  output debounced_level, input ready);
  modport sink   (input valid, input pressed, input long_pressed,
                  input debounced_level, output ready);
endinterface

`default_nettype wire

@@ rtl/bdlp_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdlp_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bdlp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bdlp_pkg::DATA_W-1:0]  pwdata,
  output logic      [bdlp_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output bdlp_pkg::cfg_ctl_t                ctl
);
  import bdlp_pkg::*;

  logic [THRESH_W-1:0] debounce_r;
  logic [THRESH_W-1:0] long_r;
  logic                enable_r;
  logic                wr;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      enable_r   <= ENABLE_RST;
    end else if (wr) begin
      case (idx)
        REG_DEBOUNCE: debounce_r <= pwdata[THRESH_W-1:0];
        REG_LONG:     long_r     <= pwdata[THRESH_W-1:0];
        REG_ENABLE:   enable_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE: prdata = {{(DATA_W-THRESH_W){1'b0}}, debounce_r};
      REG_LONG:     prdata = {{(DATA_W-THRESH_W){1'b0}}, long_r};
      REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, enable_r};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    ctl.debounce_ticks   = debounce_r;
    ctl.long_press_ticks = long_r;
    ctl.enable           = enable_r;
    ctl.flag_clr         = wr && (idx == REG_ENABLE);
  end

endmodule

`default_nettype wire

@@ rtl/bdlp_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdlp_engine #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bdlp_pkg::cfg_ctl_t  ctl,
  input  wire logic                step,
  input  wire bdlp_pkg::in_item_t  item,
  output bdlp_pkg::res_t           res
);
  import bdlp_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

  logic                   raw_last_r;
  logic                   stable_r;
  logic [COUNT_WIDTH-1:0] elapsed_r;
  logic                   press_r;
  logic                   long_r;
  logic                   supp_r;

  logic [COUNT_WIDTH-1:0] elapsed_nxt;
  logic                   stable_nxt;
  logic                   supp_nxt;
  logic                   press_set;
  logic                   long_set;
  logic                   pass_db;
  logic                   release_seen;
  logic                   press_rep;
  logic                   long_rep;

  always_comb begin
    // restart on a raw edge, else count up and stick at all ones
    if (item.level != raw_last_r) begin
      elapsed_nxt = '0;
    end else if (elapsed_r != {COUNT_WIDTH{1'b1}}) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end else begin
      elapsed_nxt = elapsed_r;
    end

    pass_db      = CMP_W'(elapsed_nxt) > CMP_W'(ctl.debounce_ticks);
    release_seen = pass_db && !stable_r && item.level;
    press_set    = release_seen && !supp_r;
    stable_nxt   = pass_db ? item.level : stable_r;
    long_set     = !stable_nxt && (CMP_W'(elapsed_nxt) > CMP_W'(ctl.long_press_ticks));
    supp_nxt     = long_set ? 1'b1 : (release_seen ? 1'b0 : supp_r);
    press_rep    = press_r || press_set;
    long_rep     = long_r || long_set;

    if (ctl.enable) begin
      res.pressed         = press_rep;
      res.long_pressed    = long_rep;
      res.debounced_level = stable_nxt;
    end else begin
      res.pressed         = 1'b0;
      res.long_pressed    = 1'b0;
      res.debounced_level = stable_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r <= 1'b1;
      stable_r   <= 1'b1;
      elapsed_r  <= '0;
      press_r    <= 1'b0;
      long_r     <= 1'b0;
      supp_r     <= 1'b0;
    end else if (ctl.flag_clr) begin
      press_r <= 1'b0;
      long_r  <= 1'b0;
    end else if (step) begin
      if (ctl.enable) begin
        raw_last_r <= item.level;
        stable_r   <= stable_nxt;
        elapsed_r  <= elapsed_nxt;
        supp_r     <= supp_nxt;
        press_r    <= press_rep && !item.take_press;
        long_r     <= long_rep && !item.take_long;
      end else begin
        press_r <= 1'b0;
        long_r  <= 1'b0;
      end
    end
  end

  a_flag_clr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.flag_clr |=> !press_r && !long_r)
    else $error("flags not cleared after enable write");

  a_edge_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && ctl.enable && !ctl.flag_clr && (item.level != raw_last_r) |=> elapsed_r == '0)
    else $error("elapsed count not restarted on raw edge");

  a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
    step && ctl.enable && !ctl.flag_clr && long_set |=> supp_r)
    else $error("long press did not set suppress mark");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && !ctl.enable && !ctl.flag_clr |=> !press_r && !long_r && $stable(elapsed_r))
    else $error("state moved while disabled");

endmodule

`default_nettype wire

@@ rtl/button_debounce_long_press_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake         Payload
// in_if     in   valid/ready       level, take_press, take_long (one 1 ms tick)
// out_if    out  valid/ready       pressed, long_pressed, debounced_level
// APB       in   psel/penable      debounce_ticks @0x0, long_press_ticks @0x4, enable @0x8
//
// One item per cycle sustained while out_if.ready stays high; a taken item passes the
// input register, then the engine into the result register, before its result is offered.
// Synchronous active-low reset returns thresholds to 50 and 1000, enable to 1, and
// the debouncer to released with no flags.
// A stalled result holds in the result register; one more item waits in the input
// register, after which in_if.ready drops until out_if takes the result.
module button_debounce_long_press_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bdlp_in_if.sink                           in_if,
  bdlp_out_if.source                        out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bdlp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bdlp_pkg::DATA_W-1:0]  pwdata,
  output logic      [bdlp_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import bdlp_pkg::*;

  cfg_ctl_t ctl;
  in_item_t item_r;
  res_t     res;
  res_t     res_r;
  logic     s1_valid_r;
  logic     out_valid_r;
  logic     advance;
  logic     step;
  logic     in_fire;

  bdlp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  bdlp_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  // result register is free when empty or being taken this cycle
  assign advance     = !out_valid_r || out_if.ready;
  assign step        = s1_valid_r && advance;
  assign in_if.ready = !s1_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: load the tick on accept, the result on step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.level      <= in_if.level;
      item_r.take_press <= in_if.take_press;
      item_r.take_long  <= in_if.take_long;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.pressed         = res_r.pressed;
  assign out_if.long_pressed    = res_r.long_pressed;
  assign out_if.debounced_level = res_r.debounced_level;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Bench for the button debouncer with long-press detection.
//
// Each item on the input channel is one 1 ms tick: raw level plus take bits for
// the two flags. The bench keeps its own copy of the debouncer state and the
// register settings, and predicts one result per accepted item. A separate
// process pops the oldest prediction for every result the block hands over and
// compares it field by field. Registers go over APB only while nothing is in flight.
//
// Order of tests:
//   registers   - reset values, masking of wide write data, unmapped address
//   directed    - zero thresholds, long press that suppresses the short one,
//                 a take on the tick that sets a flag, clearing by an enable write
//   disable     - frozen sampling while disabled, flags held clear
//   saturation  - thresholds at or one below the top of their range stay unreached
//   random      - bouncy press/release bursts over several threshold settings,
//                 the last phases with no idling on either side
module testbench;
  import bdlp_pkg::*;

  localparam int unsigned CNT_W          = 16;
  localparam int unsigned LATENCY        = 2;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_ITEMS    = 180;
  // Aligned address past the last register; writes there must be dropped
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();

  button_debounce_long_press_core #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: settings and debouncer state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0] cfg_deb;
  logic [THRESH_W-1:0] cfg_long;
  logic                cfg_en;

  logic             mdl_raw;
  logic             mdl_stable;
  logic [CNT_W-1:0] mdl_elapsed;
  logic             mdl_press;
  logic             mdl_long;
  logic             mdl_suppress;

  res_t        pending[$];     // predicted results, oldest first
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  bit          idle_on     = 1'b1;

  function automatic void model_reset();
    cfg_deb      = DEBOUNCE_RST;
    cfg_long     = LONG_RST;
    cfg_en       = ENABLE_RST;
    mdl_raw      = 1'b1;
    mdl_stable   = 1'b1;
    mdl_elapsed  = '0;
    mdl_press    = 1'b0;
    mdl_long     = 1'b0;
    mdl_suppress = 1'b0;
  endfunction

  // Advance the debouncer by one tick and return what the block reports
  function automatic res_t debounce_tick(in_item_t it);
    res_t r;
    if (cfg_en) begin
      // Restart on any raw change, else count up and stick at the top
      if (it.level != mdl_raw) begin
        mdl_elapsed = '0;
      end else if (mdl_elapsed != '1) begin
        mdl_elapsed = mdl_elapsed + 1'b1;
      end
      if (mdl_elapsed > cfg_deb) begin
        // Debounced release: flag a short press unless a long one was seen
        if (!mdl_stable && it.level) begin
          if (!mdl_suppress) begin
            mdl_press = 1'b1;
          end
          mdl_suppress = 1'b0;
        end
        mdl_stable = it.level;
      end
      if (!mdl_stable && mdl_elapsed > cfg_long) begin
        mdl_long     = 1'b1;
        mdl_suppress = 1'b1;
      end
      mdl_raw = it.level;
      // Report first, then honor the take bits
      r.pressed         = mdl_press;
      r.long_pressed    = mdl_long;
      r.debounced_level = mdl_stable;
      if (it.take_press) begin
        mdl_press = 1'b0;
      end
      if (it.take_long) begin
        mdl_long = 1'b0;
      end
    end else begin
      // Disabled: state frozen, flags held clear
      mdl_press         = 1'b0;
      mdl_long          = 1'b0;
      r.pressed         = 1'b0;
      r.long_pressed    = 1'b0;
      r.debounced_level = mdl_stable;
    end
    return r;
  endfunction

  function automatic void reg_model_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    case (addr[ADDR_W-1:2])
      REG_DEBOUNCE: cfg_deb = data[THRESH_W-1:0];
      REG_LONG:     cfg_long = data[THRESH_W-1:0];
      REG_ENABLE: begin
        // Any enable write drops both flags; the suppress mark survives
        cfg_en    = data[0];
        mdl_press = 1'b0;
        mdl_long  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] reg_model_value(reg_idx_t r);
    logic [DATA_W-1:0] v;
    v = '0;
    case (r)
      REG_DEBOUNCE: v[THRESH_W-1:0] = cfg_deb;
      REG_LONG:     v[THRESH_W-1:0] = cfg_long;
      REG_ENABLE:   v[0] = cfg_en;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t r);
    return {r, 2'b00};
  endfunction

  function automatic logic coin(int unsigned n);
    return ($urandom_range(0, n - 1) == 0);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, and the compare process
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && coin(10)) begin
      // Start a stall burst of random length, counted down in stall_left
      stall_left = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  res_t got_res;
  res_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.pressed         = out_ch.pressed;
      got_res.long_pressed    = out_ch.long_pressed;
      got_res.debounced_level = out_ch.debounced_level;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: pressed=%b long=%b level=%b",
                                  got_res.pressed, got_res.long_pressed,
                                  got_res.debounced_level));
      end else begin
        want_res = pending.pop_front();
        if (got_res.pressed !== want_res.pressed) begin
          report_mismatch($sformatf("pressed: expected %b, got %b",
                                    want_res.pressed, got_res.pressed));
        end
        if (got_res.long_pressed !== want_res.long_pressed) begin
          report_mismatch($sformatf("long_pressed: expected %b, got %b",
                                    want_res.long_pressed, got_res.long_pressed));
        end
        if (got_res.debounced_level !== want_res.debounced_level) begin
          report_mismatch($sformatf("debounced_level: expected %b, got %b",
                                    want_res.debounced_level, got_res.debounced_level));
        end
      end
    end
  end

  // Drop the run if nothing moves on any port for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task is entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one tick; predict its result once the block takes it
  task automatic send_tick(logic level, logic take_press, logic take_long);
    in_item_t it;
    int unsigned gap;
    it.level      = level;
    it.take_press = take_press;
    it.take_long  = take_long;
    if (idle_on && coin(12)) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.level      <= it.level;
    in_ch.take_press <= it.take_press;
    in_ch.take_long  <= it.take_long;
    do @(posedge clk); while (!in_ch.ready);
    pending.push_back(debounce_tick(it));
    items_sent++;
  endtask

  task automatic send_item(in_item_t it);
    send_tick(it.level, it.take_press, it.take_long);
  endtask

  task automatic random_tick();
    send_tick(1'($urandom_range(0, 1)), coin(4), coin(4));
  endtask

  // Stop offering, wait for every expected result, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_model_write(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] data);
    apb_write(reg_addr(r), data);
  endtask

  task automatic check_reg(reg_idx_t r);
    logic [DATA_W-1:0] got;
    apb_read(reg_addr(r), got);
    if (got !== reg_model_value(r)) begin
      report_mismatch($sformatf("register %s: expected 0x%08h, got 0x%08h",
                                r.name(), reg_model_value(r), got));
    end
  endtask

  task automatic check_all_regs();
    check_reg(REG_DEBOUNCE);
    check_reg(REG_LONG);
    check_reg(REG_ENABLE);
  endtask

  // One press: bounce in, hold low (with the odd glitch), bounce out, rest high
  task automatic press_burst();
    int unsigned d;
    int unsigned l;
    int unsigned hold_max;
    int unsigned rest_max;
    int unsigned n;
    d        = cfg_deb;
    l        = cfg_long;
    hold_max = (l + d + 6 > 70) ? 70 : l + d + 6;
    rest_max = (d + 6 > 40) ? 40 : d + 6;
    n = $urandom_range(0, 4);
    repeat (n) random_tick();
    n = $urandom_range(1, hold_max);
    repeat (n) send_tick(coin(20), coin(4), coin(4));
    n = $urandom_range(0, 4);
    repeat (n) random_tick();
    n = $urandom_range(1, rest_max);
    repeat (n) send_tick(!coin(20), coin(4), coin(4));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_registers();
    settle();
    check_all_regs();
    // Upper data bits must be dropped by every register
    write_reg(REG_DEBOUNCE, 32'hABCD_FFFF);
    write_reg(REG_LONG, 32'h1234_0000);
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    check_all_regs();
    write_reg(REG_ENABLE, 32'h5555_AAAB);
    // A write past the map must leave everything alone
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    check_all_regs();
    write_reg(REG_DEBOUNCE, 32'(DEBOUNCE_RST));
    write_reg(REG_LONG, 32'(LONG_RST));
    write_reg(REG_ENABLE, 32'(ENABLE_RST));
    check_all_regs();
  endtask

  task automatic test_directed();
    // Items are {level, take_press, take_long}
    in_item_t long_then_short[19] = '{
      3'b000, 3'b000, 3'b000, 3'b000,  // zero debounce: low accepted on second tick
      3'b001,                          // long flag sets and is taken on the same tick
      3'b000,                          // sets again, keep it
      3'b100, 3'b100,                  // release after a long press: no short press
      3'b101,                          // take the long flag
      3'b000, 3'b100, 3'b000, 3'b000,  // bounce, then settle low
      3'b100, 3'b110,                  // short press reported and taken at once
      3'b000, 3'b000, 3'b100, 3'b100   // short press left standing
    };
    in_item_t zero_long[3] = '{3'b000, 3'b000, 3'b111};
    settle();
    write_reg(REG_DEBOUNCE, 0);
    write_reg(REG_LONG, 3);
    foreach (long_then_short[i]) send_item(long_then_short[i]);
    // Rewriting enable with 1 must still wipe the standing flag
    settle();
    write_reg(REG_ENABLE, 1);
    send_tick(1'b1, 1'b0, 1'b0);
    // Long threshold of zero fires on the tick the level is accepted
    settle();
    write_reg(REG_LONG, 0);
    foreach (zero_long[i]) send_item(zero_long[i]);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_disable();
    settle();
    write_reg(REG_DEBOUNCE, 2);
    write_reg(REG_LONG, 8);
    repeat (6) send_tick(1'b0, 1'b0, 1'b0);
    // Freeze mid-press; everything but the flags must survive
    settle();
    write_reg(REG_ENABLE, 0);
    repeat (40) random_tick();
    settle();
    write_reg(REG_ENABLE, 1);
    repeat (8) send_tick(1'b0, coin(3), coin(3));
    repeat (12) random_tick();
  endtask

  task automatic test_saturation();
    idle_on = 1'b0;
    settle();
    // Long threshold one below the counter top: a short hold must never pass it,
    // and taking the flag every tick shows it never sets
    write_reg(REG_DEBOUNCE, 0);
    write_reg(REG_LONG, 32'h0000_FFFE);
    repeat (40) send_tick(1'b0, coin(2), 1'b1);
    // Debounce at the top can never be passed: the release is never accepted
    settle();
    write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
    repeat (40) send_tick(1'b1, coin(2), 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_random_presses();
    int unsigned deb_set[8] = '{3, 0, 1, 6, 0, 65535, 2, 4};
    int unsigned long_set[8] = '{12, 0, 5, 25, 65535, 3, 9, 16};
    int unsigned start;
    for (int p = 0; p < 8; p++) begin
      // Run the last phases flat out on both sides
      if (p == 6) begin
        idle_on = 1'b0;
      end
      settle();
      write_reg(REG_DEBOUNCE, deb_set[p]);
      write_reg(REG_LONG, long_set[p]);
      if (p % 2 == 1) begin
        write_reg(REG_ENABLE, 0);
        repeat (20) random_tick();
        settle();
        write_reg(REG_ENABLE, 1);
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (coin(7)) begin
          random_tick();
        end else begin
          press_burst();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.level      = 1'b1;
    in_ch.take_press = 1'b0;
    in_ch.take_long  = 1'b0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_registers();
    test_directed();
    test_disable();
    test_saturation();
    test_random_presses();

    settle();
    if (mismatches == 0 && pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
